/* hdl/mdtpq_pkg.sv */
// ============================================================================
// mdtpq_pkg
// Shared types and constants for the delivery-time priority queue.
// ============================================================================
package mdtpq_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int ID_W     = 31;
    localparam int TIME_W   = 16;
    localparam int WEIGHT_W = 32;
    localparam int PRIO_W   = 8;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_EXTRACT = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]     order_id;
        logic [TIME_W-1:0]   dtime;
        logic [WEIGHT_W-1:0] weight;
        logic [PRIO_W-1:0]   prio;
    } entry_t;

    typedef struct packed {
        logic   ins;
        logic   ext;
        entry_t new_entry;
    } ctrl_t;

endpackage

/* hdl/mdtpq_cell.sv */
// ============================================================================
// mdtpq_cell
// One slot of the sorted chain: holds an order and shifts it left or right.
// ============================================================================
module mdtpq_cell (
    input  logic                 aclk,
    input  mdtpq_pkg::ctrl_t     ctrl,
    input  logic                 occupied,
    input  logic                 left_gt,
    input  mdtpq_pkg::entry_t    left_entry,
    input  mdtpq_pkg::entry_t    right_entry,
    output logic                 gt,
    output mdtpq_pkg::entry_t    entry
);

    mdtpq_pkg::entry_t entry_reg;
    mdtpq_pkg::entry_t entry_next;

    // An empty slot counts as later than any new order.
    assign gt = !occupied || (entry_reg.dtime > ctrl.new_entry.dtime);

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.ins && gt) begin
            entry_next = left_gt ? left_entry : ctrl.new_entry;
        end else if (ctrl.ext) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

/* hdl/min_delivery_time_priority_queue.sv */
// ============================================================================
// min_delivery_time_priority_queue
// Bounded min-queue of orders kept sorted by delivery time in a chain of cells.
// ============================================================================
//  Channel  Direction  Ports         Beat
//  s_       in         valid/ready   one command: insert or extract
//  m_       out        valid/ready   one result per command
//
//  Every cell compares and shifts at once for each command that is taken.
//  The result appears in an output register on the cycle after acceptance.
//  A new command is taken whenever that register is empty or being drained.
//  Reset clears the count and the output valid; cell contents are not reset.
module min_delivery_time_priority_queue #(
    parameter int CAPACITY = mdtpq_pkg::CAPACITY_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_cmd,
    input  logic [mdtpq_pkg::ID_W-1:0]     s_order_id,
    input  logic [mdtpq_pkg::TIME_W-1:0]   s_delivery_time,
    input  logic [mdtpq_pkg::WEIGHT_W-1:0] s_weight_bits,
    input  logic [mdtpq_pkg::PRIO_W-1:0]   s_priority_code,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [mdtpq_pkg::STATUS_W-1:0] m_status,
    output logic [mdtpq_pkg::ID_W-1:0]     m_out_id,
    output logic [mdtpq_pkg::TIME_W-1:0]   m_out_time,
    output logic [mdtpq_pkg::WEIGHT_W-1:0] m_out_weight,
    output logic [mdtpq_pkg::PRIO_W-1:0]   m_out_priority,
    output logic [mdtpq_pkg::OCC_W-1:0]    m_occupancy
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             m_valid_reg;
    logic             accept;
    logic             full;
    logic             empty;

    mdtpq_pkg::ctrl_t               ctrl;
    mdtpq_pkg::entry_t              new_entry;
    mdtpq_pkg::entry_t              head;
    mdtpq_pkg::entry_t              res_entry;
    logic [mdtpq_pkg::STATUS_W-1:0] res_status;
    mdtpq_pkg::entry_t              res_entry_reg;
    logic [mdtpq_pkg::STATUS_W-1:0] res_status_reg;
    logic [CNT_W-1:0]               res_count_reg;

    mdtpq_pkg::entry_t cell_entry [CAPACITY];
    logic              cell_gt    [CAPACITY];
    logic              cell_occ   [CAPACITY];

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign empty   = (count_reg == '0);

    assign new_entry.order_id = s_order_id;
    assign new_entry.dtime    = s_delivery_time;
    assign new_entry.weight   = s_weight_bits;
    assign new_entry.prio     = s_priority_code;

    assign ctrl.ins       = accept && (s_cmd == mdtpq_pkg::CMD_INSERT) && !full;
    assign ctrl.ext       = accept && (s_cmd == mdtpq_pkg::CMD_EXTRACT) && !empty;
    assign ctrl.new_entry = new_entry;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++) begin : g_cell
            assign cell_occ[i] = (count_reg > CNT_W'(i));
            if (i == 0) begin : g_first
                if (CAPACITY > 1) begin : g_mid
                    mdtpq_cell u_cell (
                        .aclk        (aclk),
                        .ctrl        (ctrl),
                        .occupied    (cell_occ[i]),
                        .left_gt     (1'b0),
                        .left_entry  (new_entry),
                        .right_entry (cell_entry[i+1]),
                        .gt          (cell_gt[i]),
                        .entry       (cell_entry[i])
                    );
                end
            end else if (i == CAPACITY - 1) begin : g_last
                mdtpq_cell u_cell (
                    .aclk        (aclk),
                    .ctrl        (ctrl),
                    .occupied    (cell_occ[i]),
                    .left_gt     (cell_gt[i-1]),
                    .left_entry  (cell_entry[i-1]),
                    .right_entry ('0),
                    .gt          (cell_gt[i]),
                    .entry       (cell_entry[i])
                );
            end else begin : g_inner
                mdtpq_cell u_cell (
                    .aclk        (aclk),
                    .ctrl        (ctrl),
                    .occupied    (cell_occ[i]),
                    .left_gt     (cell_gt[i-1]),
                    .left_entry  (cell_entry[i-1]),
                    .right_entry (cell_entry[i+1]),
                    .gt          (cell_gt[i]),
                    .entry       (cell_entry[i])
                );
            end
        end
    endgenerate

    assign head = cell_entry[0];

    always_comb begin
        count_next = count_reg;
        res_status = mdtpq_pkg::STATUS_OK;
        res_entry  = '0;
        if (accept) begin
            if (s_cmd == mdtpq_pkg::CMD_INSERT) begin
                if (full) begin
                    res_status = mdtpq_pkg::STATUS_FULL;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                end
            end else begin
                if (empty) begin
                    res_status = mdtpq_pkg::STATUS_EMPTY;
                end else begin
                    res_entry  = head;
                    count_next = count_reg - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_entry_reg  <= res_entry;
            res_status_reg <= res_status;
            res_count_reg  <= count_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = res_status_reg;
    assign m_out_id       = res_entry_reg.order_id;
    assign m_out_time     = res_entry_reg.dtime;
    assign m_out_weight   = res_entry_reg.weight;
    assign m_out_priority = res_entry_reg.prio;
    assign m_occupancy    = mdtpq_pkg::OCC_W'(res_count_reg);

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("Order count exceeds capacity.");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.ins |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("Accepted insert did not raise the count.");

    a_extract_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.ext |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("Extract did not lower the count.");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid_reg)
        else $error("Accepted beat produced no result.");

    a_empty_status: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_cmd == mdtpq_pkg::CMD_EXTRACT) && empty
        |=> m_status == mdtpq_pkg::STATUS_EMPTY && m_out_id == '0)
        else $error("Extract from an empty queue reported wrongly.");

endmodule
